FILE: hdl/ctb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the timer bank.
package ctb_pkg;

   // Bank size and field widths
   localparam int NUM_TIMERS = 16;
   localparam int TIMER_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int MASK_W     = 16;
   localparam int CNT_W      = 32;
   localparam int IDX_W      = 8;
   localparam int KIND_W     = 3;

   localparam logic [TIMER_W-1:0] LAST_TIMER = TIMER_W'(NUM_TIMERS - 1);
   localparam logic [MASK_W-1:0]  VALID_MASK = MASK_W'((64'd1 << NUM_TIMERS) - 64'd1);

   // Request kinds; codes 5 to 7 change nothing
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 3'd0,
      KIND_START   = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_QUERY   = 3'd3,
      KIND_SERVICE = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_QUERY,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;      // capture request word
      logic exec;       // apply start/stop/service, launch query read
      logic walk_clr;   // restart the timer walk
      logic tick_rd;    // read counter of walked timer
      logic tick_wr;    // decrement and write back walked timer
      logic query_cap;  // capture query read data
      logic out_load;   // load response register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     walk_last;
      logic     out_free;
   } dp_status_type;

endpackage

FILE: hdl/ctb_ctrl.sv
// Sequencing state machine for the timer bank.
module ctb_ctrl
   import ctb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.walk_clr = 1'b1;
            unique case (status.kind)
               KIND_TICK:  state_in = ST_TICK_RD;
               KIND_QUERY: state_in = ST_QUERY;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_TICK_RD: begin
            cmd.tick_rd = 1'b1;
            state_in    = ST_TICK_WR;
         end
         ST_TICK_WR: begin
            cmd.tick_wr = 1'b1;
            state_in    = status.walk_last ? ST_FINISH : ST_TICK_RD;
         end
         ST_QUERY: begin
            cmd.query_cap = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/ctb_dp.sv
// Datapath: counter memory, timer flag registers and response register.
module ctb_dp
   import ctb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [IDX_W-1:0]   req_timer_index,
   input  logic [CNT_W-1:0]   req_load_count,
   input  logic               req_has_handler,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CNT_W-1:0]   rsp_remaining,
   output logic [MASK_W-1:0]  rsp_fired_mask,
   output logic [MASK_W-1:0]  rsp_pending_mask,
   output logic [MASK_W-1:0]  rsp_enabled_mask
);

   // Latched request word
   kind_type           kind_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   load_ff;
   logic               hand_ff;

   // Timer state
   logic [CNT_W-1:0]   cnt_mem [NUM_TIMERS];
   logic [CNT_W-1:0]   rd_data_ff;
   logic [MASK_W-1:0]  en_ff, en_in;
   logic [MASK_W-1:0]  pend_ff, pend_in;
   logic [MASK_W-1:0]  hand_bits_ff, hand_bits_in;
   logic [TIMER_W-1:0] walk_ff;

   // Result staging and response register
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [MASK_W-1:0]  fired_ff, fired_in;
   logic               rsp_valid_ff;
   logic [CNT_W-1:0]   rsp_remaining_ff;
   logic [MASK_W-1:0]  rsp_fired_ff;
   logic [MASK_W-1:0]  rsp_pending_ff;
   logic [MASK_W-1:0]  rsp_enabled_ff;

   logic               idx_ok;
   logic [TIMER_W-1:0] sel_timer;
   logic [MASK_W-1:0]  sel_bit;
   logic [MASK_W-1:0]  walk_bit;
   logic               walk_en;
   logic [CNT_W-1:0]   dec;
   logic [MASK_W-1:0]  fired_calc;
   logic               mem_we;
   logic [TIMER_W-1:0] mem_wr_addr;
   logic [CNT_W-1:0]   mem_wr_data;
   logic               mem_re;
   logic [TIMER_W-1:0] mem_rd_addr;

   // Address decode and walk helpers
   always_comb begin
      idx_ok     = int'(idx_ff) < NUM_TIMERS;
      sel_timer  = idx_ff[TIMER_W-1:0];
      sel_bit    = idx_ok ? (MASK_W'(1) << sel_timer) : '0;
      walk_bit   = MASK_W'(1) << walk_ff;
      walk_en    = |(en_ff & walk_bit);
      dec        = rd_data_ff - CNT_W'(1);
      fired_calc = pend_ff & hand_bits_ff & VALID_MASK;
   end

   // Flag updates and result staging
   always_comb begin
      en_in        = en_ff;
      pend_in      = pend_ff;
      hand_bits_in = hand_bits_ff;
      rem_in       = rem_ff;
      fired_in     = fired_ff;
      if (cmd.exec) begin
         rem_in   = '0;
         fired_in = '0;
         case (kind_ff)
            KIND_START: begin
               hand_bits_in = hand_ff ? (hand_bits_ff | sel_bit) : (hand_bits_ff & ~sel_bit);
               pend_in      = pend_ff & ~sel_bit;
               en_in        = en_ff | sel_bit;
            end
            KIND_STOP: begin
               en_in        = en_ff & ~sel_bit;
               pend_in      = pend_ff & ~sel_bit;
               hand_bits_in = hand_bits_ff & ~sel_bit;
            end
            KIND_SERVICE: begin
               fired_in     = fired_calc;
               pend_in      = pend_ff & ~fired_calc;
               hand_bits_in = hand_bits_ff & ~fired_calc;
            end
            default: ;
         endcase
      end
      // expiry of the walked timer
      if (cmd.tick_wr && walk_en && dec == '0) begin
         en_in = en_ff & ~walk_bit;
         if (|(hand_bits_ff & walk_bit)) begin
            pend_in = pend_ff | walk_bit;
         end
      end
      if (cmd.query_cap) begin
         rem_in = (idx_ok && |(en_ff & sel_bit)) ? rd_data_ff : '0;
      end
   end

   // Counter memory port control
   always_comb begin
      mem_we      = (cmd.exec && kind_ff == KIND_START && idx_ok) || (cmd.tick_wr && walk_en);
      mem_wr_addr = cmd.exec ? sel_timer : walk_ff;
      mem_wr_data = cmd.exec ? load_ff : dec;
      mem_re      = (cmd.exec && kind_ff == KIND_QUERY && idx_ok) || cmd.tick_rd;
      mem_rd_addr = cmd.exec ? sel_timer : walk_ff;
   end

   // Counter memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= cnt_mem[mem_rd_addr];
      end
   end

   // Request word capture and staged results
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= kind_type'(req_kind);
         idx_ff  <= req_timer_index;
         load_ff <= req_load_count;
         hand_ff <= req_has_handler;
      end
      rem_ff   <= rem_in;
      fired_ff <= fired_in;
   end

   // Timer flags and walk counter
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff        <= '0;
         pend_ff      <= '0;
         hand_bits_ff <= '0;
         walk_ff      <= '0;
      end else begin
         en_ff        <= en_in;
         pend_ff      <= pend_in;
         hand_bits_ff <= hand_bits_in;
         if (cmd.walk_clr) begin
            walk_ff <= '0;
         end else if (cmd.tick_wr) begin
            walk_ff <= walk_ff + TIMER_W'(1);
         end
      end
   end

   // Response word valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response word payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_remaining_ff <= rem_ff;
         rsp_fired_ff     <= fired_ff;
         rsp_pending_ff   <= pend_ff;
         rsp_enabled_ff   <= en_ff;
      end
   end

   assign status.kind      = kind_ff;
   assign status.walk_last = (walk_ff == LAST_TIMER);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_remaining    = rsp_remaining_ff;
   assign rsp_fired_mask   = rsp_fired_ff;
   assign rsp_pending_mask = rsp_pending_ff;
   assign rsp_enabled_mask = rsp_enabled_ff;

endmodule

FILE: hdl/countdown_timer_bank.sv
// Top level of the countdown timer bank: controller, datapath and checks.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  kind, timer_index, load_count, has_handler
//   rsp      out        rsp_valid/rsp_stall  remaining, fired_mask, pending_mask, enabled_mask
//
// One word in flight at a time. A tick walks the counter memory one timer at a time
// (read, then decrement and write back) through every timer; a query reads the selected
// counter once, and start, stop and service apply their change in the execute state.
// Reset clears the controller, the enable/pending/handler flags and the response valid;
// counters are not cleared. A stalled response holds the finished word in its register
// while the next word is already taken.
module countdown_timer_bank
   import ctb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [IDX_W-1:0]   req_timer_index,
   input  logic [CNT_W-1:0]   req_load_count,
   input  logic               req_has_handler,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CNT_W-1:0]   rsp_remaining,
   output logic [MASK_W-1:0]  rsp_fired_mask,
   output logic [MASK_W-1:0]  rsp_pending_mask,
   output logic [MASK_W-1:0]  rsp_enabled_mask
);

   dp_cmd_type    cmd;
   dp_status_type status;

   ctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ctb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_timer_index  (req_timer_index),
      .req_load_count   (req_load_count),
      .req_has_handler  (req_has_handler),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_remaining    (rsp_remaining),
      .rsp_fired_mask   (rsp_fired_mask),
      .rsp_pending_mask (rsp_pending_mask),
      .rsp_enabled_mask (rsp_enabled_mask)
   );

   // a taken request word blocks the next one until its work is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another word in flight");

   // flags never appear above the timer count
   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_enabled_mask | rsp_pending_mask) & ~VALID_MASK) == '0)
      else $error("flag set for a nonexistent timer");

   // serviced timers have their pending bit cleared in the same word
   a_fired_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fired_mask & rsp_pending_mask) == '0)
      else $error("serviced timer still pending");

endmodule
